// File: rtl/core/blc3_pkg.sv
// Shared types and constants for the 3D box line clipper.
`default_nettype none
package blc3_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned ITER_MAX = 12;
	localparam int unsigned ITER_W = 4;
	localparam int unsigned CODE_W = 6;

	// Configuration register indexes
	localparam logic [2:0] REG_AXIS_LIMITED = 3'd0;
	localparam logic [2:0] REG_X_LOW = 3'd1;
	localparam logic [2:0] REG_X_HIGH = 3'd2;
	localparam logic [2:0] REG_Y_LOW = 3'd3;
	localparam logic [2:0] REG_Y_HIGH = 3'd4;
	localparam logic [2:0] REG_Z_LOW = 3'd5;
	localparam logic [2:0] REG_Z_HIGH = 3'd6;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t sz;
		coord_t ex;
		coord_t ey;
		coord_t ez;
	} seg_t;

	typedef struct packed {
		seg_t seg;
		logic remains;
	} res_t;

	typedef struct packed {
		logic [2:0] lim;
		coord_t b0;
		coord_t b1;
		coord_t b2;
		coord_t b3;
		coord_t b4;
		coord_t b5;
	} bnd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TEST,
		ST_PICK,
		ST_MUL,
		ST_PROD,
		ST_DIV,
		ST_MOVE,
		ST_CODE,
		ST_OUT
	} bk_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} dv_state_t;

	function automatic logic [CODE_W-1:0] outcode(input bnd_t b, input coord_t x,
			input coord_t y, input coord_t z);
		logic [CODE_W-1:0] c;
		c = '0;
		if (b.lim[0]) begin
			c[0] = x < b.b0;
			c[1] = x > b.b1;
		end
		if (b.lim[1]) begin
			c[2] = y < b.b2;
			c[3] = y > b.b3;
		end
		if (b.lim[2]) begin
			c[4] = z < b.b4;
			c[5] = z > b.b5;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/blc3_div.sv
// Restoring divider: 66-bit magnitude by 33-bit magnitude, one quotient bit a cycle.
`default_nettype none
module blc3_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [65:0] num,
	input wire logic [32:0] den,
	output logic done,
	output logic [65:0] quot
);
	blc3_pkg::dv_state_t state_q, state_d;
	logic [6:0] cnt_q;
	logic [65:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [33:0] trial;
	logic [34:0] diff;

	always_comb begin
		state_d = state_q;
		case (state_q)
			blc3_pkg::DV_IDLE: if (start) state_d = blc3_pkg::DV_RUN;
			blc3_pkg::DV_RUN: if (cnt_q == 7'd65) state_d = blc3_pkg::DV_DONE;
			blc3_pkg::DV_DONE: state_d = blc3_pkg::DV_IDLE;
			default: state_d = blc3_pkg::DV_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == blc3_pkg::DV_DONE);
	end

	assign quot = quo_q;
	assign trial = {rem_q[32:0], quo_q[65]};
	assign diff = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blc3_pkg::DV_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == blc3_pkg::DV_RUN) cnt_q <= cnt_q + 7'd1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == blc3_pkg::DV_IDLE && start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (state_q == blc3_pkg::DV_RUN) begin
			if (!diff[34]) begin
				rem_q <= diff[33:0];
				quo_q <= {quo_q[64:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[64:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/blc3_front.sv
// Front end: accepts segments, computes initial outcodes, queues them for the back end.
`default_nettype none
module blc3_front #(
	parameter int unsigned DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire blc3_pkg::seg_t seg_in,
	input wire blc3_pkg::bnd_t bnd,
	output logic q_valid,
	input wire logic q_take,
	output blc3_pkg::seg_t q_seg,
	output logic [blc3_pkg::CODE_W-1:0] q_sc,
	output logic [blc3_pkg::CODE_W-1:0] q_ec
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	blc3_pkg::seg_t seg_mem [DEPTH];
	logic [blc3_pkg::CODE_W-1:0] sc_mem [DEPTH];
	logic [blc3_pkg::CODE_W-1:0] ec_mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic wr, rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign wr = push && !full;
	assign rd = q_take && q_valid;
	assign q_seg = seg_mem[rp_q];
	assign q_sc = sc_mem[rp_q];
	assign q_ec = ec_mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			seg_mem[wp_q] <= seg_in;
			sc_mem[wp_q] <= blc3_pkg::outcode(bnd, seg_in.sx, seg_in.sy, seg_in.sz);
			ec_mem[wp_q] <= blc3_pkg::outcode(bnd, seg_in.ex, seg_in.ey, seg_in.ez);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/blc3_back.sv
// Back end: iterative clipping sequencer with a shared divider and a result register.
`default_nettype none
module blc3_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_take,
	input wire blc3_pkg::seg_t q_seg,
	input wire logic [blc3_pkg::CODE_W-1:0] q_sc,
	input wire logic [blc3_pkg::CODE_W-1:0] q_ec,
	input wire blc3_pkg::bnd_t bnd,
	output logic empty,
	input wire logic pop,
	output blc3_pkg::res_t res
);
	blc3_pkg::bk_state_t state_q, state_d;
	blc3_pkg::coord_t s_q [3];
	blc3_pkg::coord_t e_q [3];
	logic [blc3_pkg::CODE_W-1:0] sc_q, ec_q;
	logic [blc3_pkg::ITER_W-1:0] iter_q;
	logic side_q;          // 0: moving start, 1: moving end
	logic [1:0] ax_q;      // clipping axis
	logic [2:0] bit_q;
	logic oth_q;           // which of the two other axes is in progress
	logic signed [32:0] num_q, den_q, nb_q;
	logic [65:0] prod;
	logic neg_q;
	logic res_full_q;
	blc3_pkg::res_t res_q;

	logic div_start, div_done;
	logic [65:0] div_q;

	logic [blc3_pkg::CODE_W-1:0] cur_code;
	logic [2:0] low_bit;
	logic [1:0] low_ax;
	logic [1:0] kax;
	blc3_pkg::coord_t bval;
	blc3_pkg::coord_t p_a, o_a, p_k, o_k;
	logic [33:0] qsat;
	logic signed [34:0] qs, sum;
	blc3_pkg::coord_t moved;
	logic test_rej, test_eq, out_free;

	// magnitude product of the registered operands feeds the divider directly
	assign prod = 66'((num_q[32] ? 33'(-num_q) : num_q)) *
		66'((nb_q[32] ? 33'(-nb_q) : nb_q));

	blc3_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(prod), .den(den_q[32] ? 33'(-den_q) : den_q),
		.done(div_done), .quot(div_q)
	);

	assign cur_code = side_q ? ec_q : sc_q;

	always_comb begin
		low_bit = 3'd0;
		for (int i = 5; i >= 0; i--) begin
			if (cur_code[i]) low_bit = 3'(i);
		end
	end
	assign low_ax = low_bit[2:1];

	always_comb begin
		case (bit_q)
			3'd0: bval = bnd.b0;
			3'd1: bval = bnd.b1;
			3'd2: bval = bnd.b2;
			3'd3: bval = bnd.b3;
			3'd4: bval = bnd.b4;
			default: bval = bnd.b5;
		endcase
	end

	// the two axes other than the clipping axis, in index order
	always_comb begin
		case (ax_q)
			2'd0: kax = oth_q ? 2'd2 : 2'd1;
			2'd1: kax = oth_q ? 2'd2 : 2'd0;
			default: kax = oth_q ? 2'd1 : 2'd0;
		endcase
	end

	assign p_a = side_q ? e_q[low_ax] : s_q[low_ax];
	assign o_a = side_q ? s_q[low_ax] : e_q[low_ax];
	assign p_k = side_q ? e_q[kax] : s_q[kax];
	assign o_k = side_q ? s_q[kax] : e_q[kax];

	assign qsat = (div_q > 66'h2_0000_0000) ? 34'h2_0000_0000 : div_q[33:0];
	assign qs = neg_q ? -35'(signed'({1'b0, qsat})) : 35'(signed'({1'b0, qsat}));
	assign sum = 35'(p_k) + qs;
	always_comb begin
		if (sum > 35'sd2147483647) moved = 32'sh7FFF_FFFF;
		else if (sum < -35'sd2147483648) moved = 32'sh8000_0000;
		else moved = sum[31:0];
	end

	assign test_rej = (sc_q & ec_q) != '0;
	assign test_eq = sc_q == ec_q;
	assign out_free = !res_full_q || pop;
	assign div_start = (state_q == blc3_pkg::ST_PROD);
	assign q_take = (state_q == blc3_pkg::ST_IDLE) && q_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			blc3_pkg::ST_IDLE: if (q_valid) state_d = blc3_pkg::ST_TEST;
			blc3_pkg::ST_TEST: begin
				if (test_rej || test_eq || iter_q == 4'(blc3_pkg::ITER_MAX))
					state_d = blc3_pkg::ST_OUT;
				else state_d = blc3_pkg::ST_PICK;
			end
			blc3_pkg::ST_PICK: state_d = blc3_pkg::ST_MUL;
			blc3_pkg::ST_MUL: state_d = blc3_pkg::ST_PROD;
			blc3_pkg::ST_PROD: state_d = blc3_pkg::ST_DIV;
			blc3_pkg::ST_DIV: if (div_done) state_d = blc3_pkg::ST_MOVE;
			blc3_pkg::ST_MOVE: begin
				if (!oth_q) state_d = blc3_pkg::ST_MUL;
				else if (!side_q && ec_q != '0) state_d = blc3_pkg::ST_PICK;
				else state_d = blc3_pkg::ST_CODE;
			end
			blc3_pkg::ST_CODE: state_d = blc3_pkg::ST_TEST;
			blc3_pkg::ST_OUT: if (out_free) state_d = blc3_pkg::ST_IDLE;
			default: state_d = blc3_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blc3_pkg::ST_IDLE;
			res_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == blc3_pkg::ST_OUT && out_free) res_full_q <= 1'b1;
			else if (pop) res_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			blc3_pkg::ST_IDLE: begin
				s_q[0] <= q_seg.sx; s_q[1] <= q_seg.sy; s_q[2] <= q_seg.sz;
				e_q[0] <= q_seg.ex; e_q[1] <= q_seg.ey; e_q[2] <= q_seg.ez;
				sc_q <= q_sc;
				ec_q <= q_ec;
				iter_q <= '0;
				side_q <= 1'b0;
			end
			blc3_pkg::ST_TEST: begin
				side_q <= (sc_q == '0);
			end
			blc3_pkg::ST_PICK: begin
				ax_q <= low_ax;
				bit_q <= low_bit;
				oth_q <= 1'b0;
			end
			blc3_pkg::ST_MUL: begin
				num_q <= 33'(bval) - 33'(p_a);
				den_q <= 33'(o_a) - 33'(p_a);
				nb_q <= 33'(o_k) - 33'(p_k);
			end
			blc3_pkg::ST_MOVE: begin
				if (den_q != '0) begin
					if (side_q) e_q[kax] <= moved;
					else s_q[kax] <= moved;
				end
				// land the clipping coordinate on the plane, then turn to the end end
				if (oth_q) begin
					if (side_q) e_q[ax_q] <= bval;
					else s_q[ax_q] <= bval;
					side_q <= 1'b1;
				end
				oth_q <= 1'b1;
			end
			blc3_pkg::ST_CODE: begin
				sc_q <= blc3_pkg::outcode(bnd, s_q[0], s_q[1], s_q[2]);
				ec_q <= blc3_pkg::outcode(bnd, e_q[0], e_q[1], e_q[2]);
				iter_q <= iter_q + 4'd1;
			end
			default: begin
			end
		endcase
		if (state_q == blc3_pkg::ST_OUT && out_free) begin
			res_q.remains <= test_eq && !test_rej && (sc_q == '0);
			if (test_eq && !test_rej && sc_q == '0) begin
				res_q.seg <= {s_q[0], s_q[1], s_q[2], e_q[0], e_q[1], e_q[2]};
			end else begin
				res_q.seg <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		neg_q <= ((num_q[32] != nb_q[32]) != den_q[32]);
	end

	assign empty = !res_full_q;
	assign res = res_q;
endmodule
`default_nettype wire

// File: rtl/core/box_line_clip_3d.sv
// Top level of the 3D box line clipper.
// box_line_clip_3d clips a segment to an axis-aligned box with six-bit outcodes.
// A front queue accepts segments and computes their first outcodes; the back end
// runs up to twelve clip iterations, each moving the start end and then the end end
// when it is outside. Each endpoint move shifts the two other coordinates, and every
// coordinate shift runs a 66-by-33 bit restoring divider that yields one bit a cycle.
// A trivial accept or reject goes straight to the output without using the divider,
// and the result is held in a register. Write configuration only while the block is
// idle.
`default_nettype none
module box_line_clip_3d #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic signed [31:0] start_x,
	input wire logic signed [31:0] start_y,
	input wire logic signed [31:0] start_z,
	input wire logic signed [31:0] end_x,
	input wire logic signed [31:0] end_y,
	input wire logic signed [31:0] end_z,
	output logic empty,
	input wire logic pop,
	output logic signed [31:0] clip_start_x,
	output logic signed [31:0] clip_start_y,
	output logic signed [31:0] clip_start_z,
	output logic signed [31:0] clip_end_x,
	output logic signed [31:0] clip_end_y,
	output logic signed [31:0] clip_end_z,
	output logic remains,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	blc3_pkg::bnd_t bnd_q;
	blc3_pkg::seg_t seg_in;
	blc3_pkg::seg_t q_seg;
	blc3_pkg::res_t res;
	logic q_valid, q_take;
	logic [blc3_pkg::CODE_W-1:0] q_sc, q_ec;

	assign cfg_ready = 1'b1;
	assign seg_in = {start_x, start_y, start_z, end_x, end_y, end_z};

	// hold the limit registers; the user writes them only between items, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				blc3_pkg::REG_AXIS_LIMITED: bnd_q.lim <= cfg_data[2:0];
				blc3_pkg::REG_X_LOW: bnd_q.b0 <= cfg_data;
				blc3_pkg::REG_X_HIGH: bnd_q.b1 <= cfg_data;
				blc3_pkg::REG_Y_LOW: bnd_q.b2 <= cfg_data;
				blc3_pkg::REG_Y_HIGH: bnd_q.b3 <= cfg_data;
				blc3_pkg::REG_Z_LOW: bnd_q.b4 <= cfg_data;
				blc3_pkg::REG_Z_HIGH: bnd_q.b5 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	blc3_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .seg_in(seg_in),
		.bnd(bnd_q), .q_valid(q_valid), .q_take(q_take), .q_seg(q_seg),
		.q_sc(q_sc), .q_ec(q_ec)
	);

	blc3_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_seg(q_seg), .q_sc(q_sc), .q_ec(q_ec), .bnd(bnd_q),
		.empty(empty), .pop(pop), .res(res)
	);

	assign clip_start_x = res.seg.sx;
	assign clip_start_y = res.seg.sy;
	assign clip_start_z = res.seg.sz;
	assign clip_end_x = res.seg.ex;
	assign clip_end_y = res.seg.ey;
	assign clip_end_z = res.seg.ez;
	assign remains = res.remains;

	// a dropped result is all zero
	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !remains) |-> (clip_start_x == 0 && clip_end_x == 0))
		else $error("rejected result carries coordinates");
	// result holds while waiting
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(remains)))
		else $error("waiting result changed");
endmodule
`default_nettype wire
